>>> design/fifo_with_peek_and_min_to_front_macros.svh
// assertion macros for the fifo with peek and min-to-front block
// used by the top level only; expects clk and rst_n in scope
`ifndef FIFO_WITH_PEEK_AND_MIN_TO_FRONT_MACROS_SVH
`define FIFO_WITH_PEEK_AND_MIN_TO_FRONT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FWP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fwp_pkg.sv
// shared types and codes for the fifo with peek and min-to-front block
// no dependencies
package fwp_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned OCOUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MIN   = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DEQ_WAIT,
    ST_PEEK_WAIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_SHIFT_LOAD,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_MIN_WR,
    ST_RD_HEAD,
    ST_RD_TAIL,
    ST_FINISH
  } state_t;

endpackage

>>> design/fwp_ram.sv
// entry store: one write port, one read port with registered read data
// depends on fwp_pkg
module fwp_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [fwp_pkg::DATA_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [fwp_pkg::DATA_W-1:0]  rdata
);

  logic [fwp_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [fwp_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/fwp_min_unit.sv
// signed compare unit tracking the first minimum during a scan
// depends on fwp_pkg
module fwp_min_unit #(
  parameter int unsigned IW = 5
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              init,
  input  logic signed [fwp_pkg::DATA_W-1:0] value,
  input  logic [IW-1:0]                     idx,
  output logic signed [fwp_pkg::DATA_W-1:0] min_value,
  output logic [IW-1:0]                     best_idx
);

  logic signed [fwp_pkg::DATA_W-1:0] min_r;
  logic [IW-1:0]                     best_r;
  logic                              take;

  // strict less keeps the first of equal minima
  assign take = init || (value < min_r);

  always_ff @(posedge clk) begin
    if (en && take) begin
      min_r  <= value;
      best_r <= idx;
    end
  end

  assign min_value = min_r;
  assign best_idx  = best_r;

endmodule

>>> design/fifo_with_peek_and_min_to_front.sv
// top level of the fifo with peek and min-to-front block: sequencer,
// pointers and result registers; uses fwp_pkg, fwp_ram, fwp_min_unit
//
//  channel  | strobe      | fields
//  ---------+-------------+--------------------------------------------------
//  input    | start/busy  | in_cmd, in_data_value, in_position
//  result   | out_valid   | out_result_value, out_item_count, out_head_value,
//           |             | out_tail_value, out_status
//
// one command at a time; busy is high from the accept edge until the result
// strobe. min-to-front scans the queue for the first minimum, shifts the entries
// ahead of it back by one and writes the minimum at the head; its length is
// set by the single read port of the store (one entry per cycle scanned/shifted).
// rst_n synchronous; it empties the queue. the store itself is not cleared.
// the receiver cannot stall: out_valid is high for exactly one cycle.
`include "fifo_with_peek_and_min_to_front_macros.svh"

module fifo_with_peek_and_min_to_front #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fwp_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [fwp_pkg::DATA_W-1:0]    in_data_value,
  input  logic [fwp_pkg::POS_W-1:0]            in_position,
  output logic                                 out_valid,
  output logic signed [fwp_pkg::DATA_W-1:0]    out_result_value,
  output logic [fwp_pkg::OCOUNT_W-1:0]         out_item_count,
  output logic signed [fwp_pkg::DATA_W-1:0]    out_head_value,
  output logic signed [fwp_pkg::DATA_W-1:0]    out_tail_value,
  output logic [1:0]                           out_status
);

  localparam int unsigned AW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > fwp_pkg::POS_W) ? CW : fwp_pkg::POS_W;

  fwp_pkg::state_t state_r, state_nxt;

  logic [fwp_pkg::CMD_W-1:0]         cmd_r;
  logic signed [fwp_pkg::DATA_W-1:0] data_r;
  logic [fwp_pkg::POS_W-1:0]         pos_r;
  logic [AW-1:0]                     head_r;
  logic [CW-1:0]                     count_r;
  logic [CW-1:0]                     idx_r;
  logic                              pipe_vld_r;
  logic [CW-1:0]                     pipe_idx_r;
  logic signed [fwp_pkg::DATA_W-1:0] value_r;
  fwp_pkg::status_t                  status_r;
  logic signed [fwp_pkg::DATA_W-1:0] head_val_r;

  logic                              out_valid_r;
  logic signed [fwp_pkg::DATA_W-1:0] out_value_r;
  logic [fwp_pkg::OCOUNT_W-1:0]      out_count_r;
  logic signed [fwp_pkg::DATA_W-1:0] out_head_r;
  logic signed [fwp_pkg::DATA_W-1:0] out_tail_r;
  logic [1:0]                        out_status_r;

  logic                              is_empty;
  logic                              is_full;
  logic                              pos_bad;
  logic [CW-1:0]                     last_idx;

  logic                              ram_we;
  logic [CW-1:0]                     wr_off;
  logic [CW-1:0]                     rd_off;
  logic [AW-1:0]                     wr_addr;
  logic [AW-1:0]                     rd_addr;
  logic signed [fwp_pkg::DATA_W-1:0] ram_wdata;
  logic signed [fwp_pkg::DATA_W-1:0] ram_rdata;
  logic                              cmp_en;
  logic signed [fwp_pkg::DATA_W-1:0] min_value;
  logic [CW-1:0]                     best_idx;

  // circular slot of an offset from the head
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return AW'(sum);
  endfunction

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign pos_bad  = (CMPW'(pos_r) >= CMPW'(count_r));
  assign last_idx = count_r - CW'(1);
  assign wr_addr  = slot_of(head_r, wr_off);
  assign rd_addr  = slot_of(head_r, rd_off);

  fwp_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  fwp_min_unit #(
    .IW (CW)
  ) u_min (
    .clk       (clk),
    .en        (cmp_en),
    .init      (pipe_idx_r == '0),
    .value     (ram_rdata),
    .idx       (pipe_idx_r),
    .min_value (min_value),
    .best_idx  (best_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fwp_pkg::ST_IDLE: begin
        if (start) state_nxt = fwp_pkg::ST_DECODE;
      end
      fwp_pkg::ST_DECODE: begin
        unique case (cmd_r)
          fwp_pkg::CMD_DEQ:  state_nxt = is_empty ? fwp_pkg::ST_RD_HEAD : fwp_pkg::ST_DEQ_WAIT;
          fwp_pkg::CMD_PEEK: state_nxt = pos_bad ? fwp_pkg::ST_RD_HEAD : fwp_pkg::ST_PEEK_WAIT;
          fwp_pkg::CMD_MIN:  state_nxt = is_empty ? fwp_pkg::ST_RD_HEAD : fwp_pkg::ST_SCAN;
          default:           state_nxt = fwp_pkg::ST_RD_HEAD;
        endcase
      end
      fwp_pkg::ST_DEQ_WAIT:   state_nxt = fwp_pkg::ST_RD_HEAD;
      fwp_pkg::ST_PEEK_WAIT:  state_nxt = fwp_pkg::ST_RD_HEAD;
      fwp_pkg::ST_SCAN: begin
        if (idx_r == last_idx) state_nxt = fwp_pkg::ST_SCAN_END;
      end
      fwp_pkg::ST_SCAN_END:   state_nxt = fwp_pkg::ST_SHIFT_LOAD;
      fwp_pkg::ST_SHIFT_LOAD: state_nxt = fwp_pkg::ST_SHIFT;
      fwp_pkg::ST_SHIFT: begin
        if (idx_r == '0) state_nxt = fwp_pkg::ST_SHIFT_END;
      end
      fwp_pkg::ST_SHIFT_END:  state_nxt = fwp_pkg::ST_MIN_WR;
      fwp_pkg::ST_MIN_WR:     state_nxt = fwp_pkg::ST_RD_HEAD;
      fwp_pkg::ST_RD_HEAD:    state_nxt = is_empty ? fwp_pkg::ST_FINISH : fwp_pkg::ST_RD_TAIL;
      fwp_pkg::ST_RD_TAIL:    state_nxt = fwp_pkg::ST_FINISH;
      fwp_pkg::ST_FINISH:     state_nxt = fwp_pkg::ST_IDLE;
      default:                state_nxt = fwp_pkg::ST_IDLE;
    endcase
  end

  // store and compare unit controls
  always_comb begin
    ram_we    = 1'b0;
    wr_off    = '0;
    ram_wdata = ram_rdata;
    rd_off    = '0;
    cmp_en    = 1'b0;
    unique case (state_r)
      fwp_pkg::ST_DECODE: begin
        if (cmd_r == fwp_pkg::CMD_ENQ) begin
          ram_we    = !is_full;
          wr_off    = count_r;
          ram_wdata = data_r;
        end else if (cmd_r == fwp_pkg::CMD_PEEK) begin
          rd_off = CW'(pos_r);
        end
      end
      fwp_pkg::ST_DEQ_WAIT: rd_off = CW'(1);
      fwp_pkg::ST_SCAN: begin
        rd_off = idx_r;
        cmp_en = pipe_vld_r;
      end
      fwp_pkg::ST_SCAN_END: cmp_en = pipe_vld_r;
      fwp_pkg::ST_SHIFT: begin
        rd_off = idx_r - CW'(1);
        ram_we = pipe_vld_r;
        wr_off = pipe_idx_r;
      end
      fwp_pkg::ST_SHIFT_END: begin
        ram_we = pipe_vld_r;
        wr_off = pipe_idx_r;
      end
      fwp_pkg::ST_MIN_WR: begin
        ram_we    = 1'b1;
        ram_wdata = min_value;
      end
      fwp_pkg::ST_RD_TAIL: rd_off = last_idx;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fwp_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == fwp_pkg::ST_FINISH);
      pipe_vld_r  <= (state_r == fwp_pkg::ST_SCAN) ||
                     ((state_r == fwp_pkg::ST_SHIFT) && (idx_r != '0));
      pipe_idx_r  <= idx_r;
      unique case (state_r)
        fwp_pkg::ST_IDLE: begin
          if (start) begin
            cmd_r    <= in_cmd;
            data_r   <= in_data_value;
            pos_r    <= in_position;
            value_r  <= '0;
            status_r <= fwp_pkg::STAT_OK;
          end
        end
        fwp_pkg::ST_DECODE: begin
          idx_r <= '0;
          unique case (cmd_r)
            fwp_pkg::CMD_ENQ: begin
              if (is_full) status_r <= fwp_pkg::STAT_FULL;
              else         count_r  <= count_r + CW'(1);
            end
            fwp_pkg::CMD_DEQ: begin
              if (is_empty) status_r <= fwp_pkg::STAT_EMPTY;
            end
            fwp_pkg::CMD_PEEK: begin
              if (pos_bad) status_r <= fwp_pkg::STAT_RANGE;
            end
            fwp_pkg::CMD_CLEAR: begin
              head_r  <= '0;
              count_r <= '0;
            end
            fwp_pkg::CMD_MIN: begin
              if (is_empty) status_r <= fwp_pkg::STAT_EMPTY;
            end
            default: begin
            end
          endcase
        end
        fwp_pkg::ST_DEQ_WAIT: begin
          value_r <= ram_rdata;
          head_r  <= rd_addr;
          count_r <= count_r - CW'(1);
        end
        fwp_pkg::ST_PEEK_WAIT: value_r <= ram_rdata;
        fwp_pkg::ST_SCAN:       idx_r <= idx_r + CW'(1);
        fwp_pkg::ST_SHIFT_LOAD: idx_r <= best_idx;
        fwp_pkg::ST_SHIFT: begin
          if (idx_r != '0) idx_r <= idx_r - CW'(1);
        end
        fwp_pkg::ST_RD_TAIL: head_val_r <= ram_rdata;
        fwp_pkg::ST_FINISH: begin
          out_value_r  <= value_r;
          out_count_r  <= fwp_pkg::OCOUNT_W'(count_r);
          out_head_r   <= is_empty ? '0 : head_val_r;
          out_tail_r   <= is_empty ? '0 : ram_rdata;
          out_status_r <= status_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy             = (state_r != fwp_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_item_count   = out_count_r;
  assign out_head_value   = out_head_r;
  assign out_tail_value   = out_tail_r;
  assign out_status       = out_status_r;

  `FWP_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "entry count beyond depth")
  `FWP_ASSERT_NEXT(a_one_beat, out_valid, !out_valid, "result beat longer than one cycle")
  `FWP_ASSERT_IMPL(a_full_count,
                   out_valid && (out_status == 2'(fwp_pkg::STAT_FULL)),
                   count_r == CW'(QUEUE_DEPTH),
                   "full status on a queue that is not full")
  `FWP_ASSERT_IMPL(a_empty_zero, out_valid && (count_r == '0),
                   (out_head_value == '0) && (out_tail_value == '0),
                   "nonzero head or tail on empty queue")

endmodule

>>> tb/fifo_with_peek_and_min_to_front_tb.sv
// self-checking testbench for fifo_with_peek_and_min_to_front: a directed table
// then random command beats, results checked against pinned rows or a queue predictor
// depends on fwp_pkg and the fifo_with_peek_and_min_to_front top level
module fifo_with_peek_and_min_to_front_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam logic [fwp_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [fwp_pkg::CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
  localparam logic signed [fwp_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [fwp_pkg::DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;
  localparam int RANDOM_PER_PHASE = 640;
  localparam int MODE_SPAN = 60;
  localparam int MAX_GAP = 30;
  localparam int END_SLACK = 2 * DEPTH + 8;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic signed [fwp_pkg::DATA_W-1:0]   value;
    logic [fwp_pkg::OCOUNT_W-1:0]        count;
    logic signed [fwp_pkg::DATA_W-1:0]   head;
    logic signed [fwp_pkg::DATA_W-1:0]   tail;
    fwp_pkg::status_t                    status;
  } fifo_result_t;

  typedef struct {
    logic [fwp_pkg::CMD_W-1:0]           cmd;
    logic signed [fwp_pkg::DATA_W-1:0]   data;
    logic [fwp_pkg::POS_W-1:0]           pos;
    int                                  reps;
    bit                                  pinned;
    fifo_result_t                        pin;
  } stim_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [fwp_pkg::CMD_W-1:0]           in_cmd = fwp_pkg::CMD_ENQ;
  logic signed [fwp_pkg::DATA_W-1:0]   in_data_value = '0;
  logic [fwp_pkg::POS_W-1:0]           in_position = '0;
  logic                                out_valid;
  logic signed [fwp_pkg::DATA_W-1:0]   out_result_value;
  logic [fwp_pkg::OCOUNT_W-1:0]        out_item_count;
  logic signed [fwp_pkg::DATA_W-1:0]   out_head_value;
  logic signed [fwp_pkg::DATA_W-1:0]   out_tail_value;
  logic [1:0]                          out_status;

  logic signed [fwp_pkg::DATA_W-1:0]   slots [DEPTH];
  int                                  head_slot = 0;
  int                                  held = 0;

  fifo_result_t                        pending_results [$];
  fifo_result_t                        want;
  stim_row_t                           directed_rows [$];
  int                                  idle_pct = 0;
  int                                  mismatch_count = 0;
  int                                  quiet_cycles = 0;
  int                                  beats_sent = 0;
  int                                  spare_sent = 0;
  int                                  results_checked = 0;
  int                                  status_tally [4] = '{0, 0, 0, 0};
  int                                  idle_plan [3] = '{0, 53, 15};

  fifo_with_peek_and_min_to_front #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_data_value    (in_data_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_item_count   (out_item_count),
    .out_head_value   (out_head_value),
    .out_tail_value   (out_tail_value),
    .out_status       (out_status)
  );

  always #2 clk = ~clk;

  function automatic fifo_result_t fifo_step(logic [fwp_pkg::CMD_W-1:0] cmd,
                                             logic signed [fwp_pkg::DATA_W-1:0] data,
                                             logic [fwp_pkg::POS_W-1:0] pos);
    fifo_result_t r;
    int best;
    logic signed [fwp_pkg::DATA_W-1:0] low;
    r.value = '0;
    r.status = fwp_pkg::STAT_OK;
    case (cmd)
      fwp_pkg::CMD_ENQ: begin
        if (held >= DEPTH) begin
          r.status = fwp_pkg::STAT_FULL;
        end else begin
          slots[(head_slot + held) % DEPTH] = data;
          held++;
        end
      end
      fwp_pkg::CMD_DEQ: begin
        if (held == 0) begin
          r.status = fwp_pkg::STAT_EMPTY;
        end else begin
          r.value = slots[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          held--;
        end
      end
      fwp_pkg::CMD_PEEK: begin
        if (int'(pos) >= held) begin
          r.status = fwp_pkg::STAT_RANGE;
        end else begin
          r.value = slots[(head_slot + int'(pos)) % DEPTH];
        end
      end
      fwp_pkg::CMD_CLEAR: begin
        head_slot = 0;
        held = 0;
      end
      fwp_pkg::CMD_MIN: begin
        if (held == 0) begin
          r.status = fwp_pkg::STAT_EMPTY;
        end else begin
          best = 0;
          low = slots[head_slot];
          for (int i = 1; i < held; i++) begin
            if (slots[(head_slot + i) % DEPTH] < low) begin
              low = slots[(head_slot + i) % DEPTH];
              best = i;
            end
          end
          for (int i = best; i > 0; i--) begin
            slots[(head_slot + i) % DEPTH] = slots[(head_slot + i - 1) % DEPTH];
          end
          slots[head_slot] = low;
        end
      end
      default: begin
      end
    endcase
    r.count = held[fwp_pkg::OCOUNT_W-1:0];
    r.head = (held == 0) ? '0 : slots[head_slot];
    r.tail = (held == 0) ? '0 : slots[(head_slot + held - 1) % DEPTH];
    return r;
  endfunction

  function automatic void add_row(logic [fwp_pkg::CMD_W-1:0] cmd,
                                  logic signed [fwp_pkg::DATA_W-1:0] data,
                                  logic [fwp_pkg::POS_W-1:0] pos, int reps, bit pinned,
                                  logic signed [fwp_pkg::DATA_W-1:0] value, int count,
                                  logic signed [fwp_pkg::DATA_W-1:0] head,
                                  logic signed [fwp_pkg::DATA_W-1:0] tail,
                                  fwp_pkg::status_t status);
    stim_row_t row;
    row.cmd = cmd;
    row.data = data;
    row.pos = pos;
    row.reps = reps;
    row.pinned = pinned;
    row.pin.value = value;
    row.pin.count = fwp_pkg::OCOUNT_W'(count);
    row.pin.head = head;
    row.pin.tail = tail;
    row.pin.status = status;
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [fwp_pkg::DATA_W-1:0] pick_value();
    logic signed [fwp_pkg::DATA_W-1:0] extreme_values [4];
    extreme_values = '{MOST_NEG, MOST_POS, '0, -1};
    case ($urandom_range(4))
      0, 1: return $urandom;
      2, 3: return int'($urandom_range(20)) - 10;
      default: return extreme_values[$urandom_range(3)];
    endcase
  endfunction

  function automatic void report_field(string name, logic signed [63:0] want_v,
                                       logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  task automatic send_beat(logic [fwp_pkg::CMD_W-1:0] cmd,
                           logic signed [fwp_pkg::DATA_W-1:0] data,
                           logic [fwp_pkg::POS_W-1:0] pos, bit pinned, fifo_result_t pin);
    fifo_result_t predicted;
    in_cmd <= cmd;
    in_data_value <= data;
    in_position <= pos;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = fifo_step(cmd, data, pos);
    pending_results.push_back(pinned ? pin : predicted);
    status_tally[predicted.status]++;
    beats_sent++;
    if (cmd > fwp_pkg::CMD_MIN) spare_sent++;
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic random_beat(int enq_weight, output bit counted);
    int roll;
    logic [fwp_pkg::CMD_W-1:0] cmd;
    logic signed [fwp_pkg::DATA_W-1:0] data;
    logic [fwp_pkg::POS_W-1:0] pos;
    fifo_result_t unused_pin;
    roll = $urandom_range(99);
    data = pick_value();
    pos = fwp_pkg::POS_W'($urandom_range(15));
    unused_pin = '{default: '0, status: fwp_pkg::STAT_OK};
    if (roll < 2) begin
      cmd = fwp_pkg::CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end else if (roll < 4) begin
      cmd = fwp_pkg::CMD_CLEAR;
    end else if (roll < 18) begin
      cmd = fwp_pkg::CMD_MIN;
    end else if (roll < 36) begin
      cmd = fwp_pkg::CMD_PEEK;
      if (held > 0 && $urandom_range(4) != 0) begin
        pos = fwp_pkg::POS_W'($urandom_range(held - 1));
      end
    end else if (roll < 36 + enq_weight) begin
      cmd = fwp_pkg::CMD_ENQ;
    end else begin
      cmd = fwp_pkg::CMD_DEQ;
    end
    counted = (cmd <= fwp_pkg::CMD_MIN);
    sender_gap();
    send_beat(cmd, data, pos, 1'b0, unused_pin);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("result_value", want.value, out_result_value);
          report_field("item_count", want.count, out_item_count);
          report_field("head_value", want.head, out_head_value);
          report_field("tail_value", want.tail, out_tail_value);
          report_field("status", want.status, out_status);
          results_checked++;
        end
      end
    end
  end

  initial begin
    bit counted;
    int sent;

    add_row(fwp_pkg::CMD_DEQ, MOST_POS, 4'd0, 1, 1'b1, 0, 0, 0, 0, fwp_pkg::STAT_EMPTY);
    add_row(fwp_pkg::CMD_PEEK, 0, 4'd0, 1, 1'b1, 0, 0, 0, 0, fwp_pkg::STAT_RANGE);
    add_row(fwp_pkg::CMD_MIN, 0, 4'd0, 1, 1'b1, 0, 0, 0, 0, fwp_pkg::STAT_EMPTY);
    add_row(CMD_SPARE_FIRST, MOST_POS, 4'd15, 1, 1'b1, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_ENQ, MOST_NEG, 4'd0, 1, 1'b1,
            0, 1, MOST_NEG, MOST_NEG, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_ENQ, MOST_POS, 4'd0, 1, 1'b1,
            0, 2, MOST_NEG, MOST_POS, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_PEEK, 0, 4'd1, 1, 1'b1,
            MOST_POS, 2, MOST_NEG, MOST_POS, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_PEEK, 0, 4'd15, 1, 1'b1,
            0, 2, MOST_NEG, MOST_POS, fwp_pkg::STAT_RANGE);
    add_row(fwp_pkg::CMD_DEQ, 0, 4'd0, 1, 1'b1,
            MOST_NEG, 1, MOST_POS, MOST_POS, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_CLEAR, 0, 4'd0, 1, 1'b1, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_ENQ, 100, 4'd0, DEPTH, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_ENQ, 7, 4'd0, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_MIN, 0, 4'd0, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_PEEK, 0, 4'd15, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_DEQ, 0, 4'd0, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_ENQ, -5, 4'd0, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_MIN, 0, 4'd0, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(fwp_pkg::CMD_PEEK, 0, 4'd0, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);
    add_row(CMD_SPARE_LAST, -1, 4'd9, 1, 1'b0, 0, 0, 0, 0, fwp_pkg::STAT_OK);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      for (int j = 0; j < directed_rows[k].reps; j++) begin
        send_beat(directed_rows[k].cmd, directed_rows[k].data - j, directed_rows[k].pos,
                  directed_rows[k].pinned, directed_rows[k].pin);
      end
    end
    hold_until_drained();

    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        random_beat(((sent / MODE_SPAN) % 2 == 0) ? 44 : 24, counted);
        if (counted) sent++;
      end
      hold_until_drained();
    end

    repeat (END_SLACK) @(posedge clk);
    $display("%0d commands (%0d spare codes) over idle rates 0/53/15, %0d results checked",
             beats_sent, spare_sent, results_checked);
    $display("status mix: %0d ok, %0d empty, %0d out of range, %0d full",
             status_tally[fwp_pkg::STAT_OK], status_tally[fwp_pkg::STAT_EMPTY],
             status_tally[fwp_pkg::STAT_RANGE], status_tally[fwp_pkg::STAT_FULL]);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
